// ----- hw/rtl/pfsm_pkg.sv -----
// Shared types, codes and reset tables of the programmable state machine.
`timescale 1ns / 1ps
`default_nettype none

package pfsm_pkg;

    localparam int STATE_COUNT_DEF = 8;
    localparam int KIND_W          = 3;
    localparam int TARGET_W        = 3;
    localparam int MASK_W          = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_STEP0    = 3'd0,
        KIND_STEP1    = 3'd1,
        KIND_SET0     = 3'd2,
        KIND_SET1     = 3'd3,
        KIND_QUERY    = 3'd4,
        KIND_DEL_ALL  = 3'd5,
        KIND_DEL_NAME = 3'd6,
        KIND_NOP      = 3'd7
    } t_kind;

    // Reset edge targets for the first eight states; pfsm_dp makes states from eight upward self loop.
    localparam int RESET_ZERO [16] = '{2, 7, 5, 0, 6, 3, 7, 4, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int RESET_ONE  [16] = '{1, 6, 4, 1, 2, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    typedef struct packed {
        logic apply;
        logic round;
        logic finish;
    } t_cmd;

endpackage

`default_nettype wire

// ----- hw/rtl/programmable_fsm_with_reachability.sv -----
// Top level of the programmable state machine with reachability-based garbage collection.
//
//   channel   handshake               payload
//   -------   ---------------------   ----------------------------------------------
//   command   start / busy            i_kind, i_target
//   result    o_valid (1-cycle pulse) o_now_state, o_garbage_mask, o_deleted_mask,
//                                     o_delete_done
//
// A command beat is taken on an edge with start high and busy low. The next beat
// is taken only after the last has passed through an apply state (step or edge
// rewrite), STATE_COUNT - 1 closure rounds over both edge tables, a finish state
// that applies deletions, and the idle state that carries the result and takes
// the next beat. The result pulses on o_valid in the cycle after finish, when
// busy is already low again, so the next beat may be issued in that same cycle.
// Reset is synchronous and active low; it returns to state B with the initial
// tables and no deleted marks. The receiver cannot stall: capture each result in
// its strobe cycle.
`timescale 1ns / 1ps
`default_nettype none

module programmable_fsm_with_reachability
    import pfsm_pkg::*;
#(
    parameter int STATE_COUNT = STATE_COUNT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [TARGET_W-1:0] i_target,
    output logic                     o_valid,
    output logic [2:0]               o_now_state,
    output logic [MASK_W-1:0]        o_garbage_mask,
    output logic [MASK_W-1:0]        o_deleted_mask,
    output logic                     o_delete_done
);

    t_cmd w_cmd;
    logic w_accept;

    // Take a command beat only while the sequencer is idle.
    assign w_accept = start & ~busy;

    pfsm_ctrl #(
        .STATE_COUNT(STATE_COUNT)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    pfsm_dp #(
        .STATE_COUNT(STATE_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_accept),
        .i_kind         (i_kind),
        .i_target       (i_target),
        .i_cmd          (w_cmd),
        .o_now_state    (o_now_state),
        .o_garbage_mask (o_garbage_mask),
        .o_deleted_mask (o_deleted_mask),
        .o_delete_done  (o_delete_done)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/pfsm_ctrl.sv -----
// Controller: sequences apply, closure rounds and finish for each item.
`timescale 1ns / 1ps
`default_nettype none

module pfsm_ctrl
    import pfsm_pkg::*;
#(
    parameter int STATE_COUNT = STATE_COUNT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output t_cmd      o_cmd,
    output logic      o_busy,
    output logic      o_valid
);

    localparam int CW = $clog2(STATE_COUNT);
    localparam logic [CW-1:0] LastRound = CW'(STATE_COUNT - 2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_CLOSE,
        ST_FINISH
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_cnt;
    logic          r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    r_cnt   <= '0;
                    r_state <= ST_CLOSE;
                end
                ST_CLOSE: begin
                    if (r_cnt == LastRound) begin
                        r_state <= ST_FINISH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_FINISH: begin
                    r_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy       = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_cmd.apply  = (r_state == ST_APPLY);
    assign o_cmd.round  = (r_state == ST_CLOSE);
    assign o_cmd.finish = (r_state == ST_FINISH);

`ifndef SYNTHESIS
    a_strobe_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_FINISH))
        else $error("result strobe without a finish cycle");
    a_accept_to_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == ST_APPLY))
        else $error("accepted beat did not enter apply");
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLOSE) |-> (r_cnt <= LastRound))
        else $error("closure round counter overran");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.apply, o_cmd.round, o_cmd.finish}))
        else $error("more than one datapath command");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/pfsm_dp.sv -----
// Datapath: current state, edge tables, deleted marks, reach closure and result registers.
`timescale 1ns / 1ps
`default_nettype none

module pfsm_dp
    import pfsm_pkg::*;
#(
    parameter int STATE_COUNT = STATE_COUNT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [TARGET_W-1:0] i_target,
    input  wire t_cmd                i_cmd,
    output logic [2:0]               o_now_state,
    output logic [MASK_W-1:0]        o_garbage_mask,
    output logic [MASK_W-1:0]        o_deleted_mask,
    output logic                     o_delete_done
);

    localparam int IW = $clog2(STATE_COUNT);

    logic [IW-1:0]          w_rst_e0 [STATE_COUNT];
    logic [IW-1:0]          w_rst_e1 [STATE_COUNT];

    for (genvar g = 0; g < STATE_COUNT; g++) begin : g_rst
        localparam int Z = (g < 8) ? (RESET_ZERO[g] % STATE_COUNT) : g;
        localparam int O = (g < 8) ? (RESET_ONE[g] % STATE_COUNT) : g;
        assign w_rst_e0[g] = IW'(Z);
        assign w_rst_e1[g] = IW'(O);
    end

    t_kind                  r_kind;
    logic [TARGET_W-1:0]    r_target;
    logic [IW-1:0]          r_cur;
    logic [IW-1:0]          r_e0 [STATE_COUNT];
    logic [IW-1:0]          r_e1 [STATE_COUNT];
    logic [STATE_COUNT-1:0] r_del;
    logic [STATE_COUNT-1:0] r_reach;

    logic                   w_target_ok;
    logic [IW-1:0]          w_tidx;
    logic [IW-1:0]          n_cur;
    logic [STATE_COUNT-1:0] n_reach;
    logic [STATE_COUNT-1:0] w_garbage;
    logic [STATE_COUNT-1:0] n_del;
    logic                   n_done;

    assign w_target_ok = (32'(r_target) < STATE_COUNT);
    assign w_tidx      = IW'(r_target);

    always_comb begin
        unique case (r_kind)
            KIND_STEP0: n_cur = r_e0[r_cur];
            KIND_STEP1: n_cur = r_e1[r_cur];
            default:    n_cur = r_cur;
        endcase
    end

    // One closure round: every reached state adds both of its successors.
    always_comb begin
        n_reach = r_reach;
        for (int i = 0; i < STATE_COUNT; i++) begin
            if (r_reach[i]) begin
                n_reach[r_e0[i]] = 1'b1;
                n_reach[r_e1[i]] = 1'b1;
            end
        end
    end

    assign w_garbage = ~r_reach & ~r_del;

    always_comb begin
        n_del  = r_del;
        n_done = 1'b0;
        if (r_kind == KIND_DEL_ALL) begin
            n_del  = r_del | w_garbage;
            n_done = |w_garbage;
        end else if (r_kind == KIND_DEL_NAME) begin
            if (w_target_ok && w_garbage[w_tidx]) begin
                n_del[w_tidx] = 1'b1;
                n_done        = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= IW'(1 % STATE_COUNT);
            r_e0  <= w_rst_e0;
            r_e1  <= w_rst_e1;
            r_del <= '0;
        end else begin
            if (i_cmd.apply) begin
                r_cur <= n_cur;
                if (w_target_ok && (r_kind == KIND_SET0)) begin
                    r_e0[r_cur] <= w_tidx;
                end
                if (w_target_ok && (r_kind == KIND_SET1)) begin
                    r_e1[r_cur] <= w_tidx;
                end
            end
            if (i_cmd.finish) begin
                r_del <= n_del;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind   <= t_kind'(i_kind);
            r_target <= i_target;
        end
        if (i_cmd.apply) begin
            r_reach <= STATE_COUNT'(1) << n_cur;
        end else if (i_cmd.round) begin
            r_reach <= n_reach;
        end
        if (i_cmd.finish) begin
            o_now_state    <= 3'(r_cur);
            o_garbage_mask <= MASK_W'(w_garbage);
            o_deleted_mask <= MASK_W'(n_del);
            o_delete_done  <= n_done;
        end
    end

endmodule

`default_nettype wire
